// ===== design/tgs_pkg.sv =====
`timescale 1ns / 1ps

package tgs_pkg;

    localparam int GRID_SIZE = 32;
    localparam int COORD_W   = $clog2(GRID_SIZE);
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int CNT_W     = CELL_W + 1;
    localparam int ADDR_W    = CELL_W + 1;
    localparam int VAL_W     = 32;
    localparam int COEF_W    = 18;
    localparam int PROD_W    = VAL_W + COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int STEP_LAT  = 4;

    localparam logic [1:0] CMD_WALL = 2'd0;
    localparam logic [1:0] CMD_COEF = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    typedef struct packed {
        logic                     we;
        logic                     sel;
        logic [1:0]               row;
        logic [1:0]               col;
        logic signed [COEF_W-1:0] value;
    } coef_wr_t;

    typedef struct packed {
        logic                   valid;
        logic                   wall;
        logic [CELL_W-1:0]      addr;
        logic [3:0][VAL_W-1:0]  f;
    } cell_in_t;

    typedef struct packed {
        logic                   valid;
        logic [CELL_W-1:0]      addr;
        logic [3:0][VAL_W-1:0]  o;
    } cell_out_t;

endpackage

// ===== design/tgs_scatter.sv =====
`timescale 1ns / 1ps

module tgs_scatter (
    input  logic               aclk,
    input  logic               aresetn,
    input  tgs_pkg::coef_wr_t  coef_wr,
    input  tgs_pkg::cell_in_t  cell_in,
    output tgs_pkg::cell_out_t cell_out
);

    logic signed [tgs_pkg::COEF_W-1:0] coef_reg [32];
    logic signed [tgs_pkg::PROD_W-1:0] prod_reg [4][4];
    logic signed [tgs_pkg::PROD_W:0]   pair_reg [4][2];
    logic [tgs_pkg::CELL_W-1:0]        cell_a_reg, cell_b_reg;
    logic                              valid_a_reg, valid_b_reg;
    logic                              out_valid_reg;
    logic [tgs_pkg::CELL_W-1:0]        out_addr_reg;
    logic [3:0][tgs_pkg::VAL_W-1:0]    out_o_reg;
    logic [3:0][tgs_pkg::VAL_W-1:0]    o_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 32; k++) coef_reg[k] <= '0;
        end else if (coef_wr.we) begin
            coef_reg[{coef_wr.sel, coef_wr.row, coef_wr.col}] <= coef_wr.value;
        end
    end

    always_comb begin
        logic signed [tgs_pkg::SUM_W-1:0] s;
        logic signed [tgs_pkg::SUM_W:0]   t;
        logic signed [tgs_pkg::SUM_W-17:0] q;
        for (int i = 0; i < 4; i++) begin
            s = tgs_pkg::SUM_W'(pair_reg[i][0]) + tgs_pkg::SUM_W'(pair_reg[i][1]);
            t = (tgs_pkg::SUM_W+1)'(s) + (tgs_pkg::SUM_W+1)'(65536);
            q = t[tgs_pkg::SUM_W:17];
            if (q > (tgs_pkg::SUM_W-16)'(32'sh7fffffff))
                o_next[i] = 32'h7fffffff;
            else if (q < -(tgs_pkg::SUM_W-16)'(33'sh080000000))
                o_next[i] = 32'h80000000;
            else
                o_next[i] = q[tgs_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                prod_reg[i][j] <= coef_reg[{cell_in.wall, 2'(j), 2'(i)}]
                                  * $signed(cell_in.f[j]);
            end
            pair_reg[i][0] <= (tgs_pkg::PROD_W+1)'(prod_reg[i][0])
                              + (tgs_pkg::PROD_W+1)'(prod_reg[i][1]);
            pair_reg[i][1] <= (tgs_pkg::PROD_W+1)'(prod_reg[i][2])
                              + (tgs_pkg::PROD_W+1)'(prod_reg[i][3]);
        end
        cell_a_reg   <= cell_in.addr;
        cell_b_reg   <= cell_a_reg;
        out_addr_reg <= cell_b_reg;
        out_o_reg    <= o_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_a_reg   <= cell_in.valid;
            valid_b_reg   <= valid_a_reg;
            out_valid_reg <= valid_b_reg;
        end
    end

    assign cell_out = {out_valid_reg, out_addr_reg, out_o_reg};

endmodule

// ===== design/tlm_grid_scatter_step_core.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Transfer when           Payload
// s_       in   s_tvalid & s_tready     tuser: cmd; tdata: cell_x .. source_sample
// m_       out  m_tvalid & m_tready     tuser: done_cmd; tdata: read_value
// cfg_     in   cfg_valid & cfg_ready   cfg_index, cfg_data
//
// A step passes one cell per cycle through the port memories and the scatter
// multiply pipeline. After reset the wall memory is cleared before the first
// command transfer. One command at a time; a finished result waits in the
// output register while the next command is taken.

module tlm_grid_scatter_step_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_x[4:0] cell_y[9:5] wall_bit[10] matrix_sel[11] coef_row[13:12]
    // coef_col[15:14] coef_value[33:16] source_sample[65:34] zero[71:66]
    input  logic [71:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value[31:0]
    output logic [31:0] m_tdata,
    // done_cmd[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_STEP  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int CW = tgs_pkg::COORD_W;
    localparam logic [CW-1:0] LAST = CW'(tgs_pkg::GRID_SIZE - 1);

    logic [2:0]  state_reg, state_next;
    logic [tgs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic        bank_reg, bank_next;
    logic        gvalid_reg, gvalid_next;
    logic [4:0]  src_x_reg, src_y_reg;
    logic [31:0] sample_reg, sample_next;
    logic [31:0] res_data_reg, res_data_next;
    logic [1:0]  res_cmd_reg, res_cmd_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    logic [31:0] pmem [4][2*tgs_pkg::CELLS];
    logic [31:0] prd_reg [4];
    logic [tgs_pkg::ADDR_W-1:0] raddr [4];
    logic        wall_mem [tgs_pkg::CELLS];
    logic        wall_rd_reg;
    logic        wall_we;
    logic [tgs_pkg::CELL_W-1:0] wall_addr;
    logic        wall_din;

    logic        p1_valid_reg, p1_src_reg;
    logic [tgs_pkg::CELL_W-1:0] p1_cell_reg;

    logic        accept;
    logic [CW-1:0] in_x, in_y, cx, cy;
    logic [CW-1:0] xm, xp, ym, yp;
    logic        issue;

    tgs_pkg::coef_wr_t  coef_wr;
    tgs_pkg::cell_in_t  cell_in;
    tgs_pkg::cell_out_t cell_out;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign in_x = s_tdata[4:0];
    assign in_y = s_tdata[9:5];
    assign cx   = cnt_reg[tgs_pkg::CELL_W-1:CW];
    assign cy   = cnt_reg[CW-1:0];
    assign issue = (state_reg == ST_STEP) && (cnt_reg < tgs_pkg::CNT_W'(tgs_pkg::CELLS));

    always_comb begin
        logic [CW-1:0] ax, ay;
        ax = (state_reg == ST_STEP) ? cx : in_x;
        ay = (state_reg == ST_STEP) ? cy : in_y;
        xm = (ax == '0) ? ax : ax - CW'(1);
        xp = (ax == LAST) ? ax : ax + CW'(1);
        ym = (ay == '0) ? ay : ay - CW'(1);
        yp = (ay == LAST) ? ay : ay + CW'(1);
        raddr[1] = {bank_reg, xm, ay};
        raddr[0] = {bank_reg, xp, ay};
        raddr[3] = {bank_reg, ax, ym};
        raddr[2] = {bank_reg, ax, yp};
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (cell_out.valid) pmem[i][{~bank_reg, cell_out.addr}] <= cell_out.o[i];
            prd_reg[i] <= pmem[i][raddr[i]];
        end
    end

    always_comb begin
        wall_we   = 1'b0;
        wall_addr = {in_x, in_y};
        wall_din  = s_tdata[10];
        if (state_reg == ST_CLEAR) begin
            wall_we   = 1'b1;
            wall_addr = cnt_reg[tgs_pkg::CELL_W-1:0];
            wall_din  = 1'b0;
        end else if (accept && s_tuser == tgs_pkg::CMD_WALL) begin
            wall_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wall_we) wall_mem[wall_addr] <= wall_din;
        wall_rd_reg <= wall_mem[cnt_reg[tgs_pkg::CELL_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        p1_cell_reg <= cnt_reg[tgs_pkg::CELL_W-1:0];
        p1_src_reg  <= (cx == src_x_reg) && (cy == src_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) p1_valid_reg <= 1'b0;
        else          p1_valid_reg <= issue;
    end

    always_comb begin
        cell_in.valid = p1_valid_reg;
        cell_in.wall  = wall_rd_reg;
        cell_in.addr  = p1_cell_reg;
        for (int j = 0; j < 4; j++) begin
            if (p1_src_reg)      cell_in.f[j] = sample_reg;
            else if (gvalid_reg) cell_in.f[j] = prd_reg[j == 0 ? 1 : j == 1 ? 0 : j == 2 ? 3 : 2];
            else                 cell_in.f[j] = '0;
        end
    end

    always_comb begin
        coef_wr.we    = accept && (s_tuser == tgs_pkg::CMD_COEF);
        coef_wr.sel   = s_tdata[11];
        coef_wr.row   = s_tdata[13:12];
        coef_wr.col   = s_tdata[15:14];
        coef_wr.value = s_tdata[33:16];
    end

    tgs_scatter u_scatter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .coef_wr  (coef_wr),
        .cell_in  (cell_in),
        .cell_out (cell_out)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        bank_next     = bank_reg;
        gvalid_next   = gvalid_reg;
        sample_next   = sample_reg;
        res_data_next = res_data_reg;
        res_cmd_next  = res_cmd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cnt_next = cnt_reg + tgs_pkg::CNT_W'(1);
                if (cnt_reg == tgs_pkg::CNT_W'(tgs_pkg::CELLS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_cmd_next  = s_tuser;
                    res_data_next = '0;
                    sample_next   = s_tdata[65:34];
                    cnt_next      = '0;
                    case (s_tuser)
                        tgs_pkg::CMD_READ: state_next = ST_READ;
                        tgs_pkg::CMD_STEP: state_next = ST_STEP;
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: begin
                res_data_next = gvalid_reg ? prd_reg[1] : '0;
                state_next    = ST_DONE;
            end
            ST_STEP: begin
                cnt_next = cnt_reg + tgs_pkg::CNT_W'(1);
                if (cnt_reg == tgs_pkg::CNT_W'(tgs_pkg::CELLS + tgs_pkg::STEP_LAT)) begin
                    bank_next   = ~bank_reg;
                    gvalid_next = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_data_reg;
                    m_tuser_next  = res_cmd_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            bank_reg     <= 1'b0;
            gvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            src_x_reg    <= '0;
            src_y_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            bank_reg     <= bank_next;
            gvalid_reg   <= gvalid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_index == 2'd0) src_x_reg <= cfg_data;
            if (cfg_valid && cfg_index == 2'd1) src_y_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        res_data_reg <= res_data_next;
        res_cmd_reg  <= res_cmd_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

endmodule
